// ===== rtl/ssf_pkg.sv =====
`default_nettype none
package ssf_pkg;

    localparam int NUM_LANES   = 4;
    localparam int ALLELE_W    = 2;
    localparam int POS_W       = 32;
    localparam int SUM_W       = 64;
    localparam int MIN_DEPTH_W = 18;
    localparam int MIN_ALT_W   = 16;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [MIN_DEPTH_W-1:0] MIN_DEPTH_RST = 18'd30;
    localparam logic [MIN_ALT_W-1:0]   MIN_ALT_RST   = 16'd5;

    // Multipliers of the per-base tests.
    localparam int FRAC_MUL   = 20;
    localparam int RATIO_MUL  = 3;
    localparam int TUMOR_MUL  = 2;
    localparam int NORMAL_MUL = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_DEPTH = 1'b0,
        CFG_MIN_ALT   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_lane_ctl;

    function automatic logic [ALLELE_W-1:0] first_set(input logic [NUM_LANES-1:0] mask);
        logic [ALLELE_W-1:0] idx;
        idx = '0;
        for (int k = NUM_LANES - 1; k >= 0; k--) begin
            if (mask[k]) begin
                idx = k[ALLELE_W-1:0];
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ssf_lane.sv =====
`default_nettype none
module ssf_lane #(
    parameter int COUNT_BITS = 16
) (
    input  wire                      i_clk,
    input  ssf_pkg::t_lane_ctl       i_ctl,
    input  wire                      i_depth_ok,
    input  wire [ssf_pkg::MIN_ALT_W-1:0] i_min_alt,
    input  wire [COUNT_BITS-1:0]     i_tumor,
    input  wire [COUNT_BITS-1:0]     i_normal,
    input  wire [COUNT_BITS+1:0]     i_tumor_depth,
    input  wire [COUNT_BITS+1:0]     i_normal_depth,
    output logic                     o_pass,
    output logic [COUNT_BITS-1:0]    o_tumor_alt,
    output logic [COUNT_BITS-1:0]    o_normal_alt,
    output logic [COUNT_BITS+1:0]    o_tumor_other,
    output logic [COUNT_BITS+1:0]    o_normal_other
);
    import ssf_pkg::*;

    localparam int DW = COUNT_BITS + 2;
    localparam int AW = (COUNT_BITS > MIN_ALT_W) ? COUNT_BITS : MIN_ALT_W;
    localparam int FW = COUNT_BITS + 5;
    localparam int TW = COUNT_BITS + 1;
    localparam int MW = COUNT_BITS + 3;
    localparam int PW = 2 * COUNT_BITS + 5;

    logic [FW-1:0] frac;
    logic [DW-1:0] na3;
    logic [TW-1:0] ta2;
    logic [MW-1:0] na5;
    logic          ok;
    logic [DW-1:0] t_rest, n_rest, t_half, n_half;

    logic [PW-1:0]         r_lhs, r_rhs;
    logic                  r_ok;
    logic [COUNT_BITS-1:0] r_ta, r_na;
    logic [DW-1:0]         r_t_oth, r_n_oth;

    always_comb begin
        frac   = FW'(i_tumor) * FW'(FRAC_MUL);
        na3    = DW'(i_normal) * DW'(RATIO_MUL);
        ta2    = TW'(i_tumor) * TW'(TUMOR_MUL);
        na5    = MW'(i_normal) * MW'(NORMAL_MUL);
        ok     = i_depth_ok
               && (AW'(i_tumor) >= AW'(i_min_alt))
               && (frac >= FW'(i_tumor_depth))
               && (DW'(i_tumor) >= na3);
        t_rest = i_tumor_depth - DW'(i_tumor);
        n_rest = i_normal_depth - DW'(i_normal);
        t_half = i_tumor_depth >> 1;
        n_half = i_normal_depth >> 1;
    end

    // First stage: the simple tests and both sides of the fraction-normalized test.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_ok    <= ok;
            r_lhs   <= PW'(ta2) * PW'(i_normal_depth);
            r_rhs   <= PW'(na5) * PW'(i_tumor_depth);
            r_ta    <= i_tumor;
            r_na    <= i_normal;
            r_t_oth <= (t_rest > t_half) ? t_rest : t_half;
            r_n_oth <= (n_rest > n_half) ? n_rest : n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_b) begin
            o_pass         <= r_ok && (r_lhs >= r_rhs);
            o_tumor_alt    <= r_ta;
            o_normal_alt   <= r_na;
            o_tumor_other  <= r_t_oth;
            o_normal_other <= r_n_oth;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ssf_merge.sv =====
`default_nettype none
module ssf_merge #(
    parameter  int COUNT_BITS = 16,
    localparam int OUT_W = ((ssf_pkg::POS_W + ssf_pkg::ALLELE_W + 4 * COUNT_BITS + 4
                             + 4 * ssf_pkg::SUM_W + 7) / 8) * 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_load,
    output logic                         o_ready,
    input  wire [ssf_pkg::POS_W-1:0]     i_pos,
    input  wire [COUNT_BITS+1:0]         i_tumor_depth,
    input  wire [COUNT_BITS+1:0]         i_normal_depth,
    input  wire [ssf_pkg::NUM_LANES-1:0] i_mask,
    input  wire [COUNT_BITS-1:0]         i_tumor_alt    [ssf_pkg::NUM_LANES],
    input  wire [COUNT_BITS-1:0]         i_normal_alt   [ssf_pkg::NUM_LANES],
    input  wire [COUNT_BITS+1:0]         i_tumor_other  [ssf_pkg::NUM_LANES],
    input  wire [COUNT_BITS+1:0]         i_normal_other [ssf_pkg::NUM_LANES],
    output logic                         o_tvalid,
    input  wire                          i_tready,
    output logic [OUT_W-1:0]             o_tdata,
    output logic                         o_tlast
);
    import ssf_pkg::*;

    localparam int DW = COUNT_BITS + 2;
    localparam int OUT_BITS = POS_W + ALLELE_W + 4 * COUNT_BITS + 4 + 4 * SUM_W;

    logic                  r_busy;
    logic [NUM_LANES-1:0]  r_mask;
    logic [POS_W-1:0]      r_pos;
    logic [DW-1:0]         r_tdp, r_ndp;
    logic [COUNT_BITS-1:0] r_ta [NUM_LANES];
    logic [COUNT_BITS-1:0] r_na [NUM_LANES];
    logic [DW-1:0]         r_to [NUM_LANES];
    logic [DW-1:0]         r_no [NUM_LANES];
    logic [SUM_W-1:0]      r_sum_ta, r_sum_to, r_sum_na, r_sum_no;
    logic                  r_out_valid, r_out_last;
    logic [OUT_W-1:0]      r_out_data;

    logic [ALLELE_W-1:0]   sel;
    logic [NUM_LANES-1:0]  rest;
    logic                  emit, last;
    logic [SUM_W-1:0]      n_sum_ta, n_sum_to, n_sum_na, n_sum_no;

    always_comb begin
        sel      = first_set(r_mask);
        rest     = r_mask & ~(NUM_LANES'(1) << sel);
        last     = (rest == '0);
        emit     = r_busy && (!r_out_valid || i_tready);
        o_ready  = !r_busy || (emit && last);
        n_sum_ta = r_sum_ta + SUM_W'(r_ta[sel]);
        n_sum_to = r_sum_to + SUM_W'(r_to[sel]);
        n_sum_na = r_sum_na + SUM_W'(r_na[sel]);
        n_sum_no = r_sum_no + SUM_W'(r_no[sel]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (emit && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mask <= i_mask;
            r_pos  <= i_pos;
            r_tdp  <= i_tumor_depth;
            r_ndp  <= i_normal_depth;
            r_ta   <= i_tumor_alt;
            r_na   <= i_normal_alt;
            r_to   <= i_tumor_other;
            r_no   <= i_normal_other;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    // The running sums advance once per call, as the call enters the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_ta <= '0;
            r_sum_to <= '0;
            r_sum_na <= '0;
            r_sum_no <= '0;
        end else if (emit) begin
            r_sum_ta <= n_sum_ta;
            r_sum_to <= n_sum_to;
            r_sum_na <= n_sum_na;
            r_sum_no <= n_sum_no;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_last <= last;
            r_out_data <= OUT_W'({n_sum_no, n_sum_na, n_sum_to, n_sum_ta, r_ndp, r_na[sel],
                                  r_tdp, r_ta[sel], sel, r_pos});
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tlast  = r_out_last;
    assign o_tdata  = r_out_data;

    // Keeps the packed field width tied to the port width.
    if (OUT_BITS > OUT_W) begin : g_width_err
        $error("output field width exceeds the port width");
    end

endmodule
`default_nettype wire

// ===== rtl/somatic_snv_filter_unit.sv =====
// Path: input, depth and lane stages, then the merge registers, then the output register.
// Throughput: one position per cycle when it makes no call and no earlier position holds
// the pipeline; the single output register emits the calls of a position one by one.
// Reset is synchronous and active low: it clears the pipeline valids, the running sums
// and the output valid, and loads min_depth = 30 and min_alt_reads = 5.
`default_nettype none
module somatic_snv_filter_unit #(
    parameter  int COUNT_BITS = 16,
    localparam int IN_W  = ssf_pkg::POS_W + 8 * COUNT_BITS,
    localparam int OUT_W = ((ssf_pkg::POS_W + ssf_pkg::ALLELE_W + 4 * COUNT_BITS + 4
                             + 4 * ssf_pkg::SUM_W + 7) / 8) * 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [ssf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [ssf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // position, tumor_a, tumor_c, tumor_g, tumor_t, normal_a, normal_c, normal_g, normal_t
    input  wire [IN_W-1:0]                s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // call_position, allele, tumor_alt, tumor_depth, normal_alt, normal_depth,
    // tumor_alt_total, tumor_other_total, normal_alt_total, normal_other_total, zero fill
    output logic [OUT_W-1:0]              m_axis_tdata,
    output logic                          m_axis_tlast
);
    import ssf_pkg::*;

    localparam int DW = COUNT_BITS + 2;
    localparam int XW = (DW > MIN_DEPTH_W) ? DW : MIN_DEPTH_W;

    logic [MIN_DEPTH_W-1:0] r_min_depth;
    logic [MIN_ALT_W-1:0]   r_min_alt;

    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [POS_W-1:0]      r_pos1, r_pos2, r_pos3, r_pos4;
    logic [COUNT_BITS-1:0] r_t1 [NUM_LANES];
    logic [COUNT_BITS-1:0] r_n1 [NUM_LANES];
    logic [COUNT_BITS-1:0] r_t2 [NUM_LANES];
    logic [COUNT_BITS-1:0] r_n2 [NUM_LANES];
    logic [DW-1:0]         r_tdp2, r_ndp2, r_tdp3, r_ndp3, r_tdp4, r_ndp4;

    logic [DW-1:0]         tdp, ndp;
    logic                  depth_ok;
    logic                  rdy1, rdy2, rdy3, rdy4;
    logic                  merge_ready, merge_load;
    t_lane_ctl             lane_ctl;

    logic [NUM_LANES-1:0]  pass;
    logic [COUNT_BITS-1:0] lane_ta [NUM_LANES];
    logic [COUNT_BITS-1:0] lane_na [NUM_LANES];
    logic [DW-1:0]         lane_to [NUM_LANES];
    logic [DW-1:0]         lane_no [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth <= MIN_DEPTH_RST;
            r_min_alt   <= MIN_ALT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_MIN_DEPTH: r_min_depth <= i_cfg_wdata[MIN_DEPTH_W-1:0];
                CFG_MIN_ALT:   r_min_alt   <= i_cfg_wdata[MIN_ALT_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage moves on when empty or the next moves; the last also when no lane passes.
    always_comb begin
        rdy4          = !r_v4 || (pass == '0) || merge_ready;
        rdy3          = !r_v3 || rdy4;
        rdy2          = !r_v2 || rdy3;
        rdy1          = !r_v1 || rdy2;
        s_axis_tready = rdy1;
        merge_load    = r_v4 && (pass != '0) && merge_ready;
        lane_ctl.en_a = rdy3;
        lane_ctl.en_b = rdy4;
        tdp = DW'(r_t1[0]) + DW'(r_t1[1]) + DW'(r_t1[2]) + DW'(r_t1[3]);
        ndp = DW'(r_n1[0]) + DW'(r_n1[1]) + DW'(r_n1[2]) + DW'(r_n1[3]);
        depth_ok = (XW'(r_tdp2) >= XW'(r_min_depth)) && (XW'(r_ndp2) >= XW'(r_min_depth));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pos1 <= s_axis_tdata[POS_W-1:0];
            for (int k = 0; k < NUM_LANES; k++) begin
                r_t1[k] <= s_axis_tdata[POS_W + k * COUNT_BITS +: COUNT_BITS];
                r_n1[k] <= s_axis_tdata[POS_W + (NUM_LANES + k) * COUNT_BITS +: COUNT_BITS];
            end
        end
        if (rdy2) begin
            r_pos2 <= r_pos1;
            r_t2   <= r_t1;
            r_n2   <= r_n1;
            r_tdp2 <= tdp;
            r_ndp2 <= ndp;
        end
        if (rdy3) begin
            r_pos3 <= r_pos2;
            r_tdp3 <= r_tdp2;
            r_ndp3 <= r_ndp2;
        end
        if (rdy4) begin
            r_pos4 <= r_pos3;
            r_tdp4 <= r_tdp3;
            r_ndp4 <= r_ndp3;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ssf_lane #(
            .COUNT_BITS(COUNT_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_ctl         (lane_ctl),
            .i_depth_ok    (depth_ok),
            .i_min_alt     (r_min_alt),
            .i_tumor       (r_t2[g]),
            .i_normal      (r_n2[g]),
            .i_tumor_depth (r_tdp2),
            .i_normal_depth(r_ndp2),
            .o_pass        (pass[g]),
            .o_tumor_alt   (lane_ta[g]),
            .o_normal_alt  (lane_na[g]),
            .o_tumor_other (lane_to[g]),
            .o_normal_other(lane_no[g])
        );
    end

    ssf_merge #(
        .COUNT_BITS(COUNT_BITS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (merge_load),
        .o_ready       (merge_ready),
        .i_pos         (r_pos4),
        .i_tumor_depth (r_tdp4),
        .i_normal_depth(r_ndp4),
        .i_mask        (pass),
        .i_tumor_alt   (lane_ta),
        .i_normal_alt  (lane_na),
        .i_tumor_other (lane_to),
        .i_normal_other(lane_no),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .o_tlast       (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/ssf_checker.sv =====
`default_nettype none
module ssf_checker #(
    parameter  int COUNT_BITS = 16,
    localparam int OUT_W = ((ssf_pkg::POS_W + ssf_pkg::ALLELE_W + 4 * COUNT_BITS + 4
                             + 4 * ssf_pkg::SUM_W + 7) / 8) * 8
) (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [OUT_W-1:0]               m_axis_tdata,
    input wire                           m_axis_tlast
);
    import ssf_pkg::*;

    localparam int P_ALLELE = POS_W;
    localparam int P_TALT   = POS_W + ALLELE_W;
    localparam int P_SUM_TA = POS_W + ALLELE_W + 4 * COUNT_BITS + 4;

    logic                  out_take;
    logic [POS_W-1:0]      call_pos;
    logic [ALLELE_W-1:0]   allele;
    logic [COUNT_BITS-1:0] tumor_alt;
    logic [SUM_W-1:0]      sum_ta;

    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign call_pos  = m_axis_tdata[POS_W-1:0];
    assign allele    = m_axis_tdata[P_ALLELE +: ALLELE_W];
    assign tumor_alt = m_axis_tdata[P_TALT +: COUNT_BITS];
    assign sum_ta    = m_axis_tdata[P_SUM_TA +: SUM_W];

    // A stalled call holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled call changed");

    // Calls of one position follow each other with no gap, at the same position.
    a_run_same_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !m_axis_tlast |=> m_axis_tvalid && (call_pos == $past(call_pos)))
        else $error("calls of one position split or changed position");

    // Bases of one position come out in rising order.
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !m_axis_tlast |=> allele > $past(allele))
        else $error("bases out of order within a position");

    // The tumor alt sum grows by exactly the next call's count.
    a_sum_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !m_axis_tlast |=> sum_ta == $past(sum_ta) + SUM_W'(tumor_alt))
        else $error("tumor alt running sum stepped wrongly");

endmodule

bind somatic_snv_filter_unit ssf_checker #(.COUNT_BITS(COUNT_BITS)) u_ssf_checker (.*);
`default_nettype wire
